FILE: rtl/core/clss_pkg.sv
`default_nettype none

package clss_pkg;

  // Motor and encoder geometry, idle limit, derivative filter and error deadband
  localparam int ENC_COUNTS_PER_REV = 16384;
  localparam int MOTOR_FULL_STEPS   = 200;
  localparam int STEP_COUNTER_MAX   = 65535;
  localparam int IDLE_TICKS         = 1000;
  localparam int FILTER_KEEP        = 64;
  localparam int FILTER_NEW         = 64;
  localparam int DEADBAND           = 30;

  localparam int HALF_REV       = ENC_COUNTS_PER_REV / 2;
  localparam int HALF_STEP_SPAN = STEP_COUNTER_MAX / 2;
  localparam int ERR_LIM        = ENC_COUNTS_PER_REV / 10;
  localparam int FULL_STEP      = ENC_COUNTS_PER_REV / MOTOR_FULL_STEPS;
  localparam int ERR_W          = $clog2(ERR_LIM + 1) + 1;

  localparam logic [31:0]       STEP_SPAN = 32'(STEP_COUNTER_MAX + 1);
  localparam logic [31:0]       ENC_MULT  = 32'(ENC_COUNTS_PER_REV);
  localparam logic signed [8:0] KEEP_COEF = 9'(FILTER_KEEP);
  localparam logic [7:0]        NEW_COEF  = 8'(FILTER_NEW);

  // Field widths
  localparam int ANGLE_W    = 14;
  localparam int COUNT_W    = 16;
  localparam int PHASE_W    = 16;
  localparam int CUR_W      = 12;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 11;
  localparam int ILIM_W     = 31;
  localparam int TURN_W     = 18;
  localparam int IDLE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOSED_LOOP_ON = 3'd0,
    CFG_GAIN_P         = 3'd1,
    CFG_GAIN_I         = 3'd2,
    CFG_GAIN_D         = 3'd3,
    CFG_STEP_SIZE      = 3'd4,
    CFG_INTEGRAL_LIMIT = 3'd5,
    CFG_CLOSED_CUR_LIM = 3'd6,
    CFG_OPEN_CURRENT   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic              closed_loop_on;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [STEP_W-1:0] step_size;
    logic [ILIM_W-1:0] integral_limit;
    logic [CUR_W-1:0]  closed_current_limit;
    logic [CUR_W-1:0]  open_current;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic evt;
    logic setpt;
    logic open_go;
    logic err;
    logic mul_i;
    logic mul_p;
    logic mul_k;
    logic mul_n;
    logic mul_d;
    logic dterm;
    logic vec;
    logic close_go;
  } dp_cmd_t;

  typedef struct packed {
    logic enabled;
    logic closed_loop;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/clss_cfg.sv
`default_nettype none

module clss_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [clss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [clss_pkg::CFG_DATA_W-1:0] cfg_data,
  output      clss_pkg::cfg_t                  cfg
);
  import clss_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closed_loop_on       <= 1'b1;
      cfg.gain_p               <= '0;
      cfg.gain_i               <= '0;
      cfg.gain_d               <= '0;
      cfg.step_size            <= STEP_W'(1);
      cfg.integral_limit       <= '0;
      cfg.closed_current_limit <= '0;
      cfg.open_current         <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLOSED_LOOP_ON: cfg.closed_loop_on       <= cfg_data[0];
        CFG_GAIN_P:         cfg.gain_p               <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_I:         cfg.gain_i               <= cfg_data[GAIN_W-1:0];
        CFG_GAIN_D:         cfg.gain_d               <= cfg_data[GAIN_W-1:0];
        CFG_STEP_SIZE:      cfg.step_size            <= cfg_data[STEP_W-1:0];
        CFG_INTEGRAL_LIMIT: cfg.integral_limit       <= cfg_data[ILIM_W-1:0];
        CFG_CLOSED_CUR_LIM: cfg.closed_current_limit <= cfg_data[CUR_W-1:0];
        CFG_OPEN_CURRENT:   cfg.open_current         <= cfg_data[CUR_W-1:0];
        default:            cfg.open_current         <= cfg.open_current;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clss_ctrl.sv
`default_nettype none

module clss_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic [1:0]           req_type,
  output      logic                 req_stall,
  input  wire clss_pkg::dp_status_t status,
  output      clss_pkg::dp_cmd_t    cmd
);
  import clss_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_EVT   = 13'b0000000000010,
    ST_SETPT = 13'b0000000000100,
    ST_OPEN  = 13'b0000000001000,
    ST_ERR   = 13'b0000000010000,
    ST_MUL_I = 13'b0000000100000,
    ST_MUL_P = 13'b0000001000000,
    ST_MUL_K = 13'b0000010000000,
    ST_MUL_N = 13'b0000100000000,
    ST_MUL_D = 13'b0001000000000,
    ST_DTERM = 13'b0010000000000,
    ST_VEC   = 13'b0100000000000,
    ST_CLOSE = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          if (req_type == REQ_TICK && status.enabled) begin
            state_next = ST_SETPT;
          end else begin
            state_next = ST_EVT;
          end
        end
      end
      ST_EVT: begin
        if (status.out_free) begin
          cmd.evt    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SETPT: begin
        cmd.setpt  = 1'b1;
        state_next = status.closed_loop ? ST_ERR : ST_OPEN;
      end
      ST_OPEN: begin
        if (status.out_free) begin
          cmd.open_go = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      ST_ERR: begin
        cmd.err    = 1'b1;
        state_next = ST_MUL_I;
      end
      ST_MUL_I: begin
        cmd.mul_i  = 1'b1;
        state_next = ST_MUL_P;
      end
      ST_MUL_P: begin
        cmd.mul_p  = 1'b1;
        state_next = ST_MUL_K;
      end
      ST_MUL_K: begin
        cmd.mul_k  = 1'b1;
        state_next = ST_MUL_N;
      end
      ST_MUL_N: begin
        cmd.mul_n  = 1'b1;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.mul_d  = 1'b1;
        state_next = ST_DTERM;
      end
      ST_DTERM: begin
        cmd.dterm  = 1'b1;
        state_next = ST_VEC;
      end
      ST_VEC: begin
        cmd.vec    = 1'b1;
        state_next = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.close_go = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clss_dp.sv
`default_nettype none

module clss_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire clss_pkg::dp_cmd_t             cmd,
  input  wire clss_pkg::cfg_t                cfg,
  input  wire logic [1:0]                    req_type,
  input  wire logic [clss_pkg::ANGLE_W-1:0]  encoder_angle,
  input  wire logic [clss_pkg::COUNT_W-1:0]  step_count,
  input  wire logic                          res_stall,
  output      clss_pkg::dp_status_t          status,
  output      logic                          res_valid,
  output      logic                          drive_active,
  output      logic [clss_pkg::PHASE_W-1:0]  phase_position,
  output      logic [clss_pkg::CUR_W-1:0]    drive_current,
  output      logic                          error_clamped
);
  import clss_pkg::*;

  // Servo state
  logic                enabled;
  logic [31:0]         step_sum;
  logic [COUNT_W-1:0]  last_step_count;
  logic [ANGLE_W-1:0]  last_angle;
  logic [TURN_W-1:0]   turn_count;
  logic [31:0]         last_position;
  logic [31:0]         last_setpoint;
  logic signed [31:0]  integral_acc;
  logic signed [31:0]  deriv_acc;
  logic [IDLE_W-1:0]   idle_ticks;

  // Working registers
  req_t                    req_q;
  logic [ANGLE_W-1:0]      angle_q;
  logic [COUNT_W-1:0]      count_q;
  logic [31:0]             setpoint_q;
  logic [31:0]             pos_q;
  logic signed [ERR_W-1:0] err_q;
  logic                    clamped_q;
  logic signed [31:0]      dpos_q;
  logic signed [ERR_W+16:0] prod_i_q;
  logic signed [ERR_W+16:0] prod_p_q;
  logic signed [40:0]      prod_k_q;
  logic [23:0]             gnd_q;
  logic signed [31:0]      keep_q;
  logic signed [56:0]      prod_d_q;
  logic signed [27:0]      vec_q;

  // Combinational next values
  logic signed [16:0]      sd;
  logic [31:0]             span;
  logic [31:0]             step_sum_next;
  logic [31:0]             setpoint_next;
  logic signed [14:0]      da;
  logic [TURN_W-1:0]       turn_next;
  logic [31:0]             pos_next;
  logic signed [31:0]      diff;
  logic signed [ERR_W-1:0] err_next;
  logic                    clamped_next;
  logic signed [ERR_W+16:0] prod_i_next;
  logic signed [ERR_W+16:0] prod_p_next;
  logic signed [33:0]      isum;
  logic signed [33:0]      ilim;
  logic signed [31:0]      integ_next;
  logic signed [57:0]      dsum;
  logic signed [31:0]      dterm_next;
  logic signed [34:0]      vsum;
  logic signed [27:0]      vec_abs;
  logic [PHASE_W-1:0]      adv;
  logic [PHASE_W-1:0]      phase_close;
  logic [CUR_W-1:0]        mag;
  logic [IDLE_W-1:0]       idle_next;
  logic [CUR_W-1:0]        cur_open;
  logic                    res_load;
  logic                    res_active_next;
  logic [PHASE_W-1:0]      res_phase_next;
  logic [CUR_W-1:0]        res_cur_next;
  logic                    res_clamped_next;

  assign status.enabled     = enabled;
  assign status.closed_loop = cfg.closed_loop_on;
  assign status.out_free    = !res_valid || !res_stall;

  always_comb begin
    // Unwrap the step counter into the setpoint
    sd   = $signed({1'b0, count_q}) - $signed({1'b0, last_step_count});
    span = {21'd0, cfg.step_size} * STEP_SPAN;
    if (int'(sd) < -HALF_STEP_SPAN) begin
      step_sum_next = step_sum + span;
    end else if (int'(sd) > HALF_STEP_SPAN) begin
      step_sum_next = step_sum - span;
    end else begin
      step_sum_next = step_sum;
    end
    setpoint_next = step_sum_next + ({21'd0, cfg.step_size} * {16'd0, count_q});

    // Unwrap encoder turns
    da = $signed({1'b0, angle_q}) - $signed({1'b0, last_angle});
    if (int'(da) > HALF_REV) begin
      turn_next = turn_count - TURN_W'(1);
    end else if (int'(da) < -HALF_REV) begin
      turn_next = turn_count + TURN_W'(1);
    end else begin
      turn_next = turn_count;
    end
    pos_next = {18'd0, angle_q} + ({{(32-TURN_W){turn_next[TURN_W-1]}}, turn_next} * ENC_MULT);

    // Error with deadband and clamp
    diff         = $signed(setpoint_q - pos_q);
    clamped_next = 1'b0;
    if (diff > -DEADBAND && diff < DEADBAND) begin
      err_next = '0;
    end else if (diff > ERR_LIM) begin
      err_next     = ERR_W'(ERR_LIM);
      clamped_next = 1'b1;
    end else if (diff < -ERR_LIM) begin
      err_next     = ERR_W'(-ERR_LIM);
      clamped_next = 1'b1;
    end else begin
      err_next = ERR_W'(diff);
    end

    prod_i_next = $signed({1'b0, cfg.gain_i}) * err_q;
    prod_p_next = $signed({1'b0, cfg.gain_p}) * err_q;

    // Integral with symmetric clamp
    isum = 34'(integral_acc) + 34'(prod_i_q / 34'sd32);
    ilim = $signed({3'b000, cfg.integral_limit});
    if (isum > ilim) begin
      integ_next = 32'(ilim);
    end else if (isum < -ilim) begin
      integ_next = 32'(-ilim);
    end else begin
      integ_next = 32'(isum);
    end

    // Low-pass derivative, saturated
    dsum = 58'(keep_q) - 58'(prod_d_q / 57'sd8);
    if (dsum > 58'sd2147483647) begin
      dterm_next = 32'sh7FFFFFFF;
    end else if (dsum < -58'sd2147483648) begin
      dterm_next = 32'sh80000000;
    end else begin
      dterm_next = dsum[31:0];
    end

    vsum = 35'(prod_p_q) + 35'(integral_acc) + 35'(deriv_acc);

    // Phase lead and current magnitude
    adv = dpos_q[PHASE_W-1:0] + {dpos_q[PHASE_W-2:0], 1'b0};
    if (vec_q > 0) begin
      phase_close = {2'b00, angle_q} + PHASE_W'(FULL_STEP) + adv;
    end else if (vec_q < 0) begin
      phase_close = {2'b00, angle_q} - PHASE_W'(FULL_STEP) + adv;
    end else begin
      phase_close = {2'b00, angle_q};
    end
    vec_abs = (vec_q < 0) ? -vec_q : vec_q;
    if (vec_abs > $signed({16'd0, cfg.closed_current_limit})) begin
      mag = cfg.closed_current_limit;
    end else begin
      mag = vec_abs[CUR_W-1:0];
    end

    // Open-loop idle current reduction
    if (setpoint_q == last_setpoint) begin
      if (idle_ticks < IDLE_W'(IDLE_TICKS)) begin
        idle_next = idle_ticks + IDLE_W'(1);
      end else begin
        idle_next = IDLE_W'(IDLE_TICKS);
      end
    end else begin
      idle_next = '0;
    end
    cur_open = (idle_next >= IDLE_W'(IDLE_TICKS)) ? {1'b0, cfg.open_current[CUR_W-1:1]}
                                                  : cfg.open_current;

    // Result select
    res_load         = cmd.evt || cmd.open_go || cmd.close_go;
    res_active_next  = 1'b0;
    res_phase_next   = '0;
    res_cur_next     = '0;
    res_clamped_next = 1'b0;
    if (cmd.open_go) begin
      res_active_next = 1'b1;
      res_phase_next  = setpoint_q[PHASE_W-1:0];
      res_cur_next    = cur_open;
    end else if (cmd.close_go) begin
      res_active_next  = 1'b1;
      res_phase_next   = phase_close;
      res_cur_next     = mag;
      res_clamped_next = clamped_q;
    end
  end

  // Servo state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b0;
      step_sum        <= '0;
      last_step_count <= '0;
      last_angle      <= '0;
      turn_count      <= '0;
      last_position   <= '0;
      last_setpoint   <= '0;
      integral_acc    <= '0;
      deriv_acc       <= '0;
      idle_ticks      <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cmd.evt) begin
        if (req_q == REQ_ENABLE) begin
          step_sum        <= {18'd0, angle_q};
          last_step_count <= '0;
          last_setpoint   <= {18'd0, angle_q};
          last_angle      <= angle_q;
          last_position   <= {18'd0, angle_q};
          turn_count      <= '0;
          enabled         <= 1'b1;
        end else if (req_q == REQ_DISABLE) begin
          enabled <= 1'b0;
        end
      end
      if (cmd.setpt) begin
        step_sum        <= step_sum_next;
        last_step_count <= count_q;
        if (cfg.closed_loop_on) begin
          turn_count <= turn_next;
        end
      end
      if (cmd.open_go) begin
        idle_ticks    <= idle_next;
        last_setpoint <= setpoint_q;
      end
      if (cmd.err) begin
        last_angle    <= angle_q;
        last_position <= pos_q;
      end
      if (cmd.mul_p) begin
        integral_acc <= integ_next;
      end
      if (cmd.dterm) begin
        deriv_acc <= dterm_next;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= req_t'(req_type);
      angle_q <= encoder_angle;
      count_q <= step_count;
    end
    if (cmd.setpt) begin
      setpoint_q <= setpoint_next;
      pos_q      <= pos_next;
    end
    if (cmd.err) begin
      err_q     <= err_next;
      clamped_q <= clamped_next;
      dpos_q    <= $signed(pos_q - last_position);
    end
    if (cmd.mul_i) begin
      prod_i_q <= prod_i_next;
    end
    if (cmd.mul_p) begin
      prod_p_q <= prod_p_next;
    end
    if (cmd.mul_k) begin
      prod_k_q <= KEEP_COEF * deriv_acc;
    end
    if (cmd.mul_n) begin
      gnd_q  <= {16'd0, NEW_COEF} * {8'd0, cfg.gain_d};
      keep_q <= 32'(prod_k_q / 41'sd128);
    end
    if (cmd.mul_d) begin
      prod_d_q <= $signed({1'b0, gnd_q}) * dpos_q;
    end
    if (cmd.vec) begin
      vec_q <= 28'(vsum / 35'sd128);
    end
    if (res_load) begin
      drive_active   <= res_active_next;
      phase_position <= res_phase_next;
      drive_current  <= res_cur_next;
      error_clamped  <= res_clamped_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/closed_loop_stepper_servo_core.sv
// Sequence: a closed-loop tick steps SETPT, ERR, MUL_I, MUL_P, MUL_K, MUL_N, MUL_D,
//   DTERM, VEC and CLOSE, an open-loop tick SETPT and OPEN, an enable, disable or ignored
//   item EVT; the final state waits while the result is stalled, and no new item is taken
//   before idle. The PID sequencer walks one multiply per cycle through a single datapath.
// Reset: rst (synchronous) clears the servo state, restores default registers and
//   drops any pending result.
`default_nettype none

module closed_loop_stepper_servo_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [clss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [clss_pkg::CFG_DATA_W-1:0] cfg_data,
  // request channel
  input  wire logic                            req_valid,
  output      logic                            req_stall,
  input  wire logic [1:0]                      req_type,
  input  wire logic [clss_pkg::ANGLE_W-1:0]    encoder_angle,
  input  wire logic [clss_pkg::COUNT_W-1:0]    step_count,
  // result channel
  output      logic                            res_valid,
  input  wire logic                            res_stall,
  output      logic                            drive_active,
  output      logic [clss_pkg::PHASE_W-1:0]    phase_position,
  output      logic [clss_pkg::CUR_W-1:0]      drive_current,
  output      logic                            error_clamped
);
  import clss_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Register file: the user must write only while no transaction is in flight, unenforced.
  clss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: accept one request transaction, then step the datapath through setpoint
  // unwrap, error, the PID multiplies and the output stage (open loop: setpoint and output;
  // events: event stage only). It holds in the final state until the result register is free.
  clss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_type),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: servo state, working registers and the result register that
  // separates the request side from the result side.
  clss_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg            (cfg),
    .req_type       (req_type),
    .encoder_angle  (encoder_angle),
    .step_count     (step_count),
    .res_stall      (res_stall),
    .status         (status),
    .res_valid      (res_valid),
    .drive_active   (drive_active),
    .phase_position (phase_position),
    .drive_current  (drive_current),
    .error_clamped  (error_clamped)
  );

`ifndef SYNTHESIS
  // The sequencer is busy right after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while sequencer stayed idle");

  // A result only appears out of a busy sequencer.
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result published without a transaction in flight");

  // The error clamp flag only comes from closed-loop ticks.
  a_current_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && drive_active && error_clamped |-> cfg.closed_loop_on)
    else $error("error clamp flagged outside closed-loop mode");

  // Closed-loop current never exceeds its limit.
  a_current_clamp: assert property (@(posedge clk) disable iff (rst)
    res_valid && drive_active && cfg.closed_loop_on |->
      drive_current <= cfg.closed_current_limit)
    else $error("closed-loop current above limit");
`endif

endmodule

`default_nettype wire
